// ----- hw/rtl/i2a_pkg.sv -----
// ----------------------------------------------------------------------------
// i2a_pkg
// shared constants and types for the binary to decimal text converter
// ----------------------------------------------------------------------------
package i2a_pkg;

  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned CHAR_W  = 8;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'd45;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [CHAR_W-1:0]  char_t;

  // commands from the sequencer to the conversion unit
  typedef struct packed {
    logic load;         // take a new magnitude and start conversion
    logic digit_shift;  // drop the top decimal digit
  } dab_ctl_t;

endpackage

// ----- hw/rtl/int32_to_decimal_ascii.sv -----
// ----------------------------------------------------------------------------
// int32_to_decimal_ascii
// binary value to decimal ascii text, most significant digit first
// ----------------------------------------------------------------------------
//
//  channel  dir  tdata                        tuser          tlast
//  s_axis   in   value[VALUE_WIDTH-1:0]       is_signed      -
//  m_axis   out  text_char[7:0]               -              last
//
// one item in gives 1 to NDIG+1 characters out ('-', then digits, no
// leading zeros). an item is accepted, converted by the bit-serial double
// dabble over its VALUE_WIDTH bits, then its NDIG decimal digit positions
// are shifted out, leading zeros dropped, after a minus if there is one.
// a new item is taken only once the last digit of the one before is registered.
// reset clears the sequencer and the output valid; a stall on m_axis holds
// the character register and holds the sequence at its next character.
// ----------------------------------------------------------------------------
module int32_to_decimal_ascii #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // item in
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,   // value, zero fill
  input  logic [0:0]                           s_axis_tuser,   // is_signed
  // item out
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [7:0]                           m_axis_tdata,   // text_char
  output logic                                 m_axis_tlast    // last
);
  import i2a_pkg::*;

  // decimal digits needed for 2^VALUE_WIDTH - 1 (1233/4096 ~ log10 2)
  localparam int unsigned NDIG = (VALUE_WIDTH * 1233) / 4096 + 1;
  localparam int unsigned RW   = $clog2(NDIG + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]             state;
  logic                   sign_pend;   // minus still to be sent
  logic                   started;     // first nonzero digit seen
  logic [RW-1:0]          remaining;   // digit positions left in the bcd register

  logic [VALUE_WIDTH-1:0] in_value;
  logic                   in_neg;
  logic [VALUE_WIDTH-1:0] in_mag;

  dab_ctl_t               dab_ctl;
  logic                   dab_busy;
  digit_t                 top_digit;

  logic                   out_free;
  logic                   s_accept;
  logic                   skip_zero;
  logic                   emit_digit;
  logic                   emit_sign;

  assign s_axis_tready = (state == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // magnitude of the input; the most negative value wraps to its true magnitude
  assign in_value = s_axis_tdata[VALUE_WIDTH-1:0];
  assign in_neg   = s_axis_tuser[0] && in_value[VALUE_WIDTH-1];
  assign in_mag   = in_neg ? (~in_value + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : in_value;

  // output register is free when empty or being taken this cycle
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // emit sequence: sign first, then drop leading zeros, then digits
  assign emit_sign  = (state == ST_EMIT) && sign_pend && out_free;
  assign skip_zero  = (state == ST_EMIT) && !sign_pend && !started &&
                      (top_digit == '0) && (remaining > RW'(1));
  assign emit_digit = (state == ST_EMIT) && !sign_pend && !skip_zero && out_free;

  assign dab_ctl.load        = s_accept;
  assign dab_ctl.digit_shift = skip_zero || emit_digit;

  i2a_dabble #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NDIG        (NDIG)
  ) u_dabble (
    .clk        (clk),
    .rst        (rst),
    .ctl        (dab_ctl),
    .load_value (in_mag),
    .busy       (dab_busy),
    .top_digit  (top_digit)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      sign_pend <= 1'b0;
      started   <= 1'b0;
      remaining <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_accept) begin
            state     <= ST_CONV;
            sign_pend <= in_neg;
            started   <= 1'b0;
            remaining <= RW'(NDIG);
          end
        end
        ST_CONV: begin
          if (!dab_busy) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit_sign) begin
            sign_pend <= 1'b0;
          end
          if (skip_zero) begin
            remaining <= remaining - 1'b1;
          end
          if (emit_digit) begin
            started   <= 1'b1;
            remaining <= remaining - 1'b1;
            if (remaining == RW'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output character register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit_sign || emit_digit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_sign) begin
      m_axis_tdata <= ASCII_MINUS;
      m_axis_tlast <= 1'b0;
    end else if (emit_digit) begin
      m_axis_tdata <= ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
      m_axis_tlast <= (remaining == RW'(1));
    end
  end

endmodule

// ----- hw/rtl/i2a_dabble.sv -----
// ----------------------------------------------------------------------------
// i2a_dabble
// bit-serial double dabble, one binary bit per cycle, then digit shift-out
// ----------------------------------------------------------------------------
module i2a_dabble #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned NDIG        = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  i2a_pkg::dab_ctl_t      ctl,
  input  logic [VALUE_WIDTH-1:0] load_value,
  output logic                   busy,
  output i2a_pkg::digit_t        top_digit
);
  import i2a_pkg::*;

  localparam int unsigned CW    = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned BCD_W = NDIG * DIGIT_W;

  logic [VALUE_WIDTH-1:0] bin;
  logic [BCD_W-1:0]       bcd;
  logic [BCD_W-1:0]       bcd_adj;
  logic [CW-1:0]          count;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] >= 4'd5) begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + 4'd3;
      end else begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.load) begin
      count <= CW'(VALUE_WIDTH);
    end else if (count != '0) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      bin <= load_value;
      bcd <= '0;
    end else if (count != '0) begin
      bcd <= {bcd_adj[BCD_W-2:0], bin[VALUE_WIDTH-1]};
      bin <= {bin[VALUE_WIDTH-2:0], 1'b0};
    end else if (ctl.digit_shift) begin
      bcd <= {bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
    end
  end

  assign busy      = (count != '0);
  assign top_digit = bcd[BCD_W-1 -: DIGIT_W];

endmodule

// ----- tb/int32_to_decimal_ascii_tb.sv -----
// ----------------------------------------------------------------------------
// int32_to_decimal_ascii_tb
// self-checking bench for the binary to decimal ascii converter: numbers go
// in on s_axis in random bursts, the expected character string of each
// accepted number is worked out here and every character leaving m_axis is
// checked against it, with the output side stalling on its own pattern
// ----------------------------------------------------------------------------
module int32_to_decimal_ascii_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2a_pkg::*;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned DEC_RADIX   = 10;
  localparam int unsigned MAX_DIGITS  = 10;   // 4294967295 has ten digits
  localparam int          RANDOM_NUMS = 430;
  localparam int          DRAIN_CYCLES = 80;
  localparam int          MAX_REPORTS = 40;

  // one number as it travels on s_axis
  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic                   is_signed;
  } number_t;

  // one character as it should leave m_axis
  typedef struct packed {
    char_t text_char;
    logic  last;
  } text_item_t;

  logic clk;
  logic rst;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [VALUE_WIDTH-1:0] s_axis_tdata  = '0;   // value
  logic [0:0]             s_axis_tuser  = '0;   // is_signed
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [7:0]             m_axis_tdata;         // text_char
  logic                   m_axis_tlast;         // last

  number_t    number_q[$];   // numbers waiting to be sent, front is on the bus
  text_item_t text_q[$];     // characters still owed by the block
  logic       number_taken = 1'b0;
  int         bad_count = 0;

  // sender burst shaping
  int burst_left = 1;
  int gap_left   = 0;
  // receiver stall shaping
  int ready_left = 0;

  int32_to_decimal_ascii #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // decimal text of one number: optional minus, digits msd first,
  // no leading zeros, last flag on the final character
  function automatic void spell_decimal(input number_t num);
    logic [VALUE_WIDTH-1:0] mag;
    char_t                  digs [MAX_DIGITS];
    int                     nd;
    mag = num.value;
    nd  = 0;
    if (num.is_signed && num.value[VALUE_WIDTH-1]) begin
      text_q.push_back({ASCII_MINUS, 1'b0});
      // two's complement negate, the most negative value wraps onto
      // its own true magnitude when read as unsigned
      mag = -num.value;
    end
    if (mag == '0) begin
      text_q.push_back({ASCII_ZERO, 1'b1});
    end else begin
      while (mag != '0) begin
        digs[nd] = ASCII_ZERO + char_t'(mag % DEC_RADIX);
        nd++;
        mag = mag / DEC_RADIX;
      end
      for (int i = nd - 1; i >= 0; i--) begin
        text_q.push_back({digs[i], i == 0});
      end
    end
  endfunction

  // input side: sample at the rising edge, predict on every accepted number
  always @(posedge clk) begin
    number_taken <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      spell_decimal({s_axis_tdata, s_axis_tuser[0]});
    end
  end

  // output side: every accepted character against the oldest one owed
  always @(posedge clk) begin
    text_item_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (text_q.size() == 0) begin
        bad_count++;
        if (bad_count <= MAX_REPORTS) begin
          $display("%0t: unexpected item char 0x%02h last %0b", $time, m_axis_tdata,
                   m_axis_tlast);
        end
      end else begin
        want = text_q.pop_front();
        if (m_axis_tdata !== want.text_char || m_axis_tlast !== want.last) begin
          bad_count++;
          if (bad_count <= MAX_REPORTS) begin
            $display("%0t: char expected 0x%02h last %0b, got char 0x%02h last %0b",
                     $time, want.text_char, want.last, m_axis_tdata, m_axis_tlast);
          end
        end
      end
    end
  end

  // driver: falling edge, bursts of numbers with random gaps between them;
  // a number stays on the bus until the block takes it
  always @(negedge clk) begin
    logic    nxt_valid;
    number_t nxt;
    nxt_valid = s_axis_tvalid;
    nxt       = {s_axis_tdata, s_axis_tuser[0]};
    if (rst) begin
      nxt_valid = 1'b0;
    end else if (!s_axis_tvalid || number_taken) begin
      if (number_taken) begin
        void'(number_q.pop_front());
      end
      nxt_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (number_q.size() != 0) begin
        nxt_valid = 1'b1;
        nxt       = number_q[0];
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          // a quarter of the bursts run straight into the next one
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
        end
      end
    end
    s_axis_tvalid <= nxt_valid;
    s_axis_tdata  <= nxt.value;
    s_axis_tuser  <= nxt.is_signed;
  end

  // receiver: alternating ready runs and stall runs, now and then a long
  // stretch with no stall at all
  always @(negedge clk) begin
    logic nxt_ready;
    nxt_ready = m_axis_tready;
    if (ready_left > 0) begin
      ready_left--;
    end else if (m_axis_tready) begin
      nxt_ready  = 1'b0;
      ready_left = $urandom_range(0, 20);
    end else begin
      nxt_ready  = 1'b1;
      ready_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(0, 30);
    end
    m_axis_tready <= nxt_ready;
  end

  // stimulus and end of run
  initial begin
    logic [VALUE_WIDTH-1:0] v;
    logic [VALUE_WIDTH-1:0] pw;
    logic                   sgn;
    rst = 1'b1;

    // directed: zero, digit-count edges, the extremes both ways, and the
    // most negative value that has no positive twin
    number_q.push_back({32'd0,          1'b0});
    number_q.push_back({32'd0,          1'b1});
    number_q.push_back({32'd1,          1'b1});
    number_q.push_back({32'd9,          1'b0});
    number_q.push_back({32'd10,         1'b0});
    number_q.push_back({32'd99,         1'b1});
    number_q.push_back({32'd100,        1'b0});
    number_q.push_back({32'd999999999,  1'b0});
    number_q.push_back({32'd1000000000, 1'b1});
    number_q.push_back({32'hFFFF_FFFF,  1'b0});
    number_q.push_back({32'hFFFF_FFFF,  1'b1});
    number_q.push_back({32'h8000_0000,  1'b1});
    number_q.push_back({32'h8000_0000,  1'b0});
    number_q.push_back({32'h8000_0001,  1'b1});
    number_q.push_back({32'h7FFF_FFFF,  1'b1});
    number_q.push_back({32'h7FFF_FFFF,  1'b0});
    number_q.push_back({32'hFFFF_FFF6,  1'b1});
    number_q.push_back({32'hFFFF_FFF6,  1'b0});
    number_q.push_back({32'd4000000000, 1'b0});
    number_q.push_back({32'hAAAA_AAAA,  1'b1});
    number_q.push_back({32'h5555_5555,  1'b0});
    number_q.push_back({32'hC465_3600,  1'b1});

    // random: mostly spread over all digit counts, plus powers of ten
    // and their neighbors, negatives of all sizes and the signed extremes
    for (int n = 0; n < RANDOM_NUMS; n++) begin
      sgn = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 7))
        0: begin
          v = $urandom();
        end
        5: begin
          pw = 1;
          repeat ($urandom_range(0, 9)) pw = pw * DEC_RADIX;
          v = pw + $urandom_range(0, 2) - 1;
        end
        6: begin
          v   = -($urandom() >> $urandom_range(0, 31));
          sgn = 1'b1;
        end
        7: begin
          v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
          v = v ^ $urandom_range(0, 1);
        end
        default: begin
          v = $urandom() >> $urandom_range(0, 31);
        end
      endcase
      number_q.push_back({v, sgn});
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (number_q.size() != 0) @(posedge clk);
    while (text_q.size() != 0) @(posedge clk);
    // anything the block still emits now shows up as unexpected
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (bad_count == 0) begin
      $display("int32_to_decimal_ascii_tb OK");
    end else begin
      $display("int32_to_decimal_ascii_tb NOT OK");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #(10_000_000);
    $display("%0t: timeout, %0d items still owed", $time, text_q.size());
    $display("int32_to_decimal_ascii_tb NOT OK");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/i2a_pkg.sv
hw/rtl/i2a_dabble.sv
hw/rtl/int32_to_decimal_ascii.sv
tb/int32_to_decimal_ascii_tb.sv
